// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`endif

// ===== hw/rtl/ppra_pkg.sv =====
// Types and constants of the paged resize allocator.
// Depends on nothing.
`default_nettype none
package ppra_pkg;
  localparam int unsigned PidW = 4;
  localparam int unsigned SizeW = 24;
  localparam int unsigned PsW = 16;
  localparam int unsigned TfW = 9;
  localparam int unsigned PagesW = 9;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegPageSize = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTotalFrames = 1'b1;
  localparam logic [PsW-1:0] PageSizeRst = 16'd32;
  localparam logic [TfW-1:0] TotalFramesRst = 9'd256;
  typedef struct packed {
    logic [PidW-1:0]  proc_id;
    logic [SizeW-1:0] new_size;
  } req_t;
  typedef struct packed {
    logic              status;
    logic [PagesW-1:0] pages_after;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ppra_if.sv =====
// Valid/ready channel carrying one word of type req_t or rsp_t.
// Depends on ppra_pkg.
`default_nettype none
interface ppra_req_if;
  logic valid;
  logic ready;
  ppra_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
interface ppra_rsp_if;
  logic valid;
  logic ready;
  ppra_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppra_div.sv =====
// Restoring divider, one quotient bit per cycle, 41-bit dividend by 16-bit divisor.
// Depends on nothing.
`default_nettype none
module ppra_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [40:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [40:0]      quo_o
);
  logic [40:0] q_q, q_d;
  logic [15:0] r_q, r_d;
  logic [16:0] t;
  logic [5:0]  n_q, n_d;
  logic        busy_q, busy_d;
  always_comb begin
    q_d = q_q; r_d = r_q; n_d = n_q; busy_d = busy_q; done_o = 1'b0;
    t = {r_q, q_q[40]};
    if (start_i) begin
      q_d = num_i; r_d = '0; n_d = 6'd41; busy_d = 1'b1;
    end else if (busy_q) begin
      q_d = {q_q[39:0], 1'b0};
      if (t >= {1'b0, den_i}) begin
        r_d = 16'(t - {1'b0, den_i}); q_d[0] = 1'b1;
      end else begin
        r_d = t[15:0];
      end
      n_d = n_q - 6'd1;
      if (n_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end
  assign quo_o = q_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; n_q <= '0;
    end else begin
      busy_q <= busy_d; n_q <= n_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/paged_process_resize_allocator_top.sv =====
// Paged resize allocator: frame bitmap and page table in synchronous memories, page
// counts, a sequencer and a serial divider. Depends on ppra_pkg, ppra_if, ppra_div.
// Steps: a compare, the division, then a drop pass (a read and a write state per page) or
// a count and a take pass over up to total_frames frames (at most MAX_FRAMES); equal size
// answers at the compare. One request at a time. Also depends on assert_macros.svh.
// Reset clears counts and control at once, then a pass over every entry clears the bitmap.
`default_nettype none
`include "assert_macros.svh"
module paged_process_resize_allocator_top #(
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned MAX_PAGES = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [ppra_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ppra_pkg::CfgDataW-1:0] cfg_data_i,
  ppra_req_if.sink req,
  ppra_rsp_if.source rsp
);
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FCW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PCW = $clog2(MAX_PAGES + 1);
  localparam int unsigned SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned AW = SW + PW;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_DECIDE = 3'd2,
    S_DROPRD = 3'd3, S_DROPWR = 3'd4, S_COUNT = 3'd5, S_TAKE = 3'd6, S_CLR = 3'd7;

  logic [ppra_pkg::PsW-1:0] ps_q;
  logic [ppra_pkg::TfW-1:0] tf_q;
  logic [2:0] st_q;
  logic [PCW-1:0] cnt_q [MAX_PROCS];
  logic [SW-1:0] pid_q;
  logic [PCW-1:0] count_q;
  logic [40:0] need_q;
  logic grow_q;
  logic [FCW-1:0] idx_q, scan_q, avail_q;
  logic [FW-1:0] mem_rd;
  logic [FW-1:0] pt [2**AW];
  logic [FW-1:0] pt_rd_q;
  logic fm [MAX_FRAMES];
  logic fm_rd_q;
  logic rd_v_q;
  logic [FW-1:0] rd_addr_q;
  logic fm_we, fm_wdata;
  logic [FW-1:0] fm_waddr;
  logic rd_issue;
  logic rsp_v_q;
  ppra_pkg::rsp_t rsp_q;

  logic [15:0] ps_eff;
  logic [PCW+15:0] prod;
  logic [40:0] cur, diff, num;
  logic div_start, div_done;
  logic [40:0] quo;
  assign ps_eff = (ps_q == '0) ? 16'd1 : ps_q;
  assign prod = (PCW+16)'(count_q) * (PCW+16)'(ps_eff);
  assign cur = 41'(prod);
  ppra_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(ps_eff),
    .done_o(div_done), .quo_o(quo));

  wire [40:0] want = 41'(req.data.new_size);
  logic [40:0] want_q;
  assign diff = grow_q ? (want_q - cur + 41'(ps_eff) - 41'd1) : (cur - want_q);
  assign num = diff;
  assign req.ready = (st_q == S_IDLE) && !rsp_v_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data = rsp_q;
  wire [AW-1:0] top_addr = {pid_q, PW'(count_q - PCW'(1))};
  wire [AW-1:0] app_addr = {pid_q, PW'(count_q)};
  wire [FW-1:0] idx_f = FW'(idx_q);
  wire take_now = (st_q == S_TAKE) && rd_v_q && !fm_rd_q && (need_q != '0);

  // bitmap reads run one address ahead of the write, so no entry is hit twice
  assign rd_issue = (idx_q < scan_q) &&
    ((st_q == S_COUNT) || ((st_q == S_TAKE) && (need_q != '0)));

  always_comb begin
    fm_we = 1'b0; fm_waddr = idx_f; fm_wdata = 1'b0;
    case (st_q)
      S_CLR: fm_we = 1'b1;
      S_DROPWR: begin
        fm_we = 1'b1; fm_waddr = mem_rd;
      end
      S_TAKE: begin
        fm_we = take_now; fm_waddr = rd_addr_q; fm_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) fm[fm_waddr] <= fm_wdata;
    fm_rd_q <= fm[idx_f];
    rd_addr_q <= idx_f;
  end

  always_ff @(posedge clk_i) begin
    if (take_now) pt[app_addr] <= rd_addr_q;
    pt_rd_q <= pt[top_addr];
  end
  assign mem_rd = pt_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= ppra_pkg::PageSizeRst; tf_q <= ppra_pkg::TotalFramesRst;
      st_q <= S_CLR; idx_q <= '0; rsp_v_q <= 1'b0; rd_v_q <= 1'b0;
      for (int k = 0; k < MAX_PROCS; k++) cnt_q[k] <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= (st_q == S_DECIDE) && (cur != want_q);
      rd_v_q <= rd_issue;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ppra_pkg::RegPageSize: ps_q <= cfg_data_i;
          ppra_pkg::RegTotalFrames: tf_q <= cfg_data_i[ppra_pkg::TfW-1:0];
          default: ;
        endcase
      end
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      case (st_q)
        S_CLR: if (idx_q == FCW'(MAX_FRAMES - 1)) begin
          idx_q <= '0; st_q <= S_IDLE;
        end else idx_q <= idx_q + FCW'(1);
        S_IDLE: if (req.valid && req.ready) begin
          if (32'(req.data.proc_id) >= MAX_PROCS) begin
            rsp_q <= '{status: 1'b1, pages_after: '0}; rsp_v_q <= 1'b1;
          end else begin
            pid_q <= SW'(req.data.proc_id);
            count_q <= cnt_q[SW'(req.data.proc_id)];
            want_q <= want;
            st_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          scan_q <= (32'(tf_q) < MAX_FRAMES) ? FCW'(tf_q) : FCW'(MAX_FRAMES);
          idx_q <= '0; avail_q <= '0;
          if (cur == want_q) begin
            rsp_q <= '{status: 1'b0, pages_after: ppra_pkg::PagesW'(count_q)};
            rsp_v_q <= 1'b1; st_q <= S_IDLE;
          end else begin
            grow_q <= cur < want_q; st_q <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          if (grow_q) begin
            need_q <= quo; st_q <= S_COUNT;
          end else begin
            need_q <= (quo > 41'(count_q)) ? 41'(count_q) : quo;
            st_q <= S_DROPRD;
          end
        end
        S_DROPRD: if (need_q == '0) begin
          cnt_q[pid_q] <= count_q;
          rsp_q <= '{status: 1'b0, pages_after: ppra_pkg::PagesW'(count_q)};
          rsp_v_q <= 1'b1; st_q <= S_IDLE;
        end else st_q <= S_DROPWR;
        S_DROPWR: begin
          count_q <= count_q - PCW'(1); need_q <= need_q - 41'd1;
          st_q <= S_DROPRD;
        end
        S_COUNT: begin
          if (rd_v_q && !fm_rd_q) avail_q <= avail_q + FCW'(1);
          if (idx_q < scan_q) idx_q <= idx_q + FCW'(1);
          else if (!rd_v_q) begin
            idx_q <= '0;
            if (41'(avail_q) < need_q || 41'(count_q) + need_q > 41'(MAX_PAGES)) begin
              rsp_q <= '{status: 1'b1, pages_after: ppra_pkg::PagesW'(count_q)};
              rsp_v_q <= 1'b1; st_q <= S_IDLE;
            end else st_q <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (take_now) begin
            count_q <= count_q + PCW'(1); need_q <= need_q - 41'd1;
          end
          if (idx_q < scan_q && need_q != '0) idx_q <= idx_q + FCW'(1);
          else if (!rd_v_q) begin
            cnt_q[pid_q] <= count_q;
            rsp_q <= '{status: 1'b0, pages_after: ppra_pkg::PagesW'(count_q)};
            rsp_v_q <= 1'b1; st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_acc_busy, req.valid && req.ready && rsp_v_q, "accept while result pending")
  `ASSERT_CLK(a_rsp_hold, rsp_v_q && !rsp.ready |=> rsp_v_q && $stable(rsp_q), "result dropped")
  `ASSERT_CLK(a_take_cnt, take_now |-> count_q < PCW'(MAX_PAGES), "page table overflow")
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the paged resize allocator: drives resize words and
// configuration writes, predicts status and page count, and checks every response word.
// Depends on ppra_pkg, ppra_if and paged_process_resize_allocator_top.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = 256;
  localparam int NPROCS = 16;
  localparam int NPAGES = 256;
  localparam int SETTLE = 900;
  localparam int WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ppra_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ppra_pkg::CfgDataW-1:0] cfg_data_i = '0;

  ppra_req_if req ();
  ppra_rsp_if rsp ();

  paged_process_resize_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req), .rsp(rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator shadow state
  bit frame_used [NFRAMES];
  logic [7:0] frame_of [NPROCS][NPAGES];
  int page_cnt [NPROCS];
  int bytes_per_page;
  int frames_scanned;

  ppra_pkg::rsp_t expected_rsp_q [$];
  int errors = 0;
  int burst_left = 0;
  int rx_hold = 0;
  int rx_pct = 100;

  function automatic ppra_pkg::rsp_t resize_predict(input int pid, input longint want);
    ppra_pkg::rsp_t r;
    longint ps, cur, drop, need, avail;
    int scan, cnt;
    ps = (bytes_per_page == 0) ? 1 : bytes_per_page;
    scan = (frames_scanned > NFRAMES) ? NFRAMES : frames_scanned;
    cnt = page_cnt[pid];
    cur = cnt * ps;
    r.status = 1'b0;
    if (cur > want) begin
      drop = (cur - want) / ps;
      if (drop > cnt) drop = cnt;
      for (int i = 0; i < drop; i++) frame_used[frame_of[pid][cnt-1-i]] = 1'b0;
      cnt -= int'(drop);
    end else if (cur < want) begin
      need = (want - cur + ps - 1) / ps;
      avail = 0;
      for (int i = 0; i < scan; i++) if (!frame_used[i]) avail++;
      if (avail < need || cnt + need > NPAGES) begin
        r.status = 1'b1;
      end else begin
        for (int i = 0; i < scan && need > 0; i++) begin
          if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            frame_of[pid][cnt] = 8'(i);
            cnt++;
            need--;
          end
        end
      end
    end
    page_cnt[pid] = cnt;
    r.pages_after = ppra_pkg::PagesW'(cnt);
    return r;
  endfunction

  task automatic req_idle();
    req.valid <= 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_resize(input logic [ppra_pkg::PidW-1:0] pid,
                             input logic [ppra_pkg::SizeW-1:0] sz);
    ppra_pkg::req_t w;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 2))
        @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    w.proc_id = pid;
    w.new_size = sz;
    req.valid <= 1'b1;
    req.data <= w;
    do @(posedge clk_i); while (!req.ready);
    expected_rsp_q.push_back(resize_predict(int'(pid), longint'(sz)));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_idle();
    wait (expected_rsp_q.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [ppra_pkg::CfgIdxW-1:0] idx,
                           input logic [ppra_pkg::CfgDataW-1:0] val);
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ppra_pkg::RegPageSize) bytes_per_page = int'(val);
    else frames_scanned = int'(val[ppra_pkg::TfW-1:0]);
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk_i) begin
    ppra_pkg::rsp_t exp_w;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d pages=%0d", $time,
                 rsp.data.status, rsp.data.pages_after);
        errors++;
      end else begin
        exp_w = expected_rsp_q.pop_front();
        if (rsp.data.status !== exp_w.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_w.status,
                   rsp.data.status);
        if (rsp.data.pages_after !== exp_w.pages_after)
          $display("%0t: pages_after expected %0d actual %0d", $time,
                   exp_w.pages_after, rsp.data.pages_after);
        if (rsp.data !== exp_w) errors++;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) begin
      case ($urandom_range(0, 2))
        0: rx_pct <= 100;
        1: rx_pct <= 70;
        default: rx_pct <= 25;
      endcase
    end
  end

  function automatic logic [ppra_pkg::SizeW-1:0] pick_size();
    int ps;
    ps = (bytes_per_page == 0) ? 1 : bytes_per_page;
    case ($urandom_range(0, 9))
      0: return ppra_pkg::SizeW'($urandom);
      1: return '0;
      default: return ppra_pkg::SizeW'(longint'($urandom_range(0, 40)) * ps +
                                        $urandom_range(0, ps - 1));
    endcase
  endfunction

  task automatic test_directed();
    send_resize(4'd0, 24'd0);
    send_resize(4'd0, 24'd1);
    send_resize(4'd0, 24'd64);
    send_resize(4'd0, 24'd64);
    send_resize(4'd0, 24'd40);
    send_resize(4'd15, 24'hFFFFFF);
    send_resize(4'd15, 24'd8192);
    send_resize(4'd0, 24'd32);
    send_resize(4'd15, 24'd8191);
    send_resize(4'd15, 24'd0);
    cfg_write(ppra_pkg::RegPageSize, 16'd0);
    send_resize(4'd3, 24'd255);
    send_resize(4'd4, 24'd2);
    send_resize(4'd3, 24'd0);
    cfg_write(ppra_pkg::RegTotalFrames, 16'd0);
    send_resize(4'd5, 24'd1);
    send_resize(4'd4, 24'd0);
    cfg_write(ppra_pkg::RegTotalFrames, 16'd511);
    cfg_write(ppra_pkg::RegPageSize, 16'd1);
    send_resize(4'd6, 24'd256);
    send_resize(4'd7, 24'd1);
    cfg_write(ppra_pkg::RegTotalFrames, 16'd8);
    send_resize(4'd6, 24'd100);
    send_resize(4'd7, 24'd1);
    send_resize(4'd6, 24'd0);
    cfg_write(ppra_pkg::RegPageSize, 16'd65535);
    send_resize(4'd8, 24'hFFFFFF);
    send_resize(4'd8, 24'd0);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) send_resize(4'($urandom_range(0, 15)), '0);
      else send_resize(4'($urandom_range(0, 15)), pick_size());
    end
  endtask

  task automatic test_back_pressure();
    rx_hold = 3000;
    test_random(30);
    wait_drained();
    test_random(30);
  endtask

  task automatic test_config_sweep();
    logic [ppra_pkg::CfgDataW-1:0] ps_set [6] =
      '{16'd32, 16'd1, 16'd7, 16'd65535, 16'd0, 16'd100};
    logic [ppra_pkg::CfgDataW-1:0] tf_set [6] =
      '{16'd256, 16'd1, 16'd300, 16'd64, 16'd511, 16'd200};
    for (int p = 0; p < 6; p++) begin
      cfg_write(ppra_pkg::RegPageSize, ps_set[p]);
      cfg_write(ppra_pkg::RegTotalFrames, tf_set[p]);
      test_random(200);
    end
  endtask

  initial begin
    bytes_per_page = int'(ppra_pkg::PageSizeRst);
    frames_scanned = int'(ppra_pkg::TotalFramesRst);
    foreach (frame_used[i]) frame_used[i] = 1'b0;
    foreach (page_cnt[i]) page_cnt[i] = 0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_back_pressure();
    test_config_sweep();
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ppra_pkg.sv
hw/rtl/ppra_if.sv
hw/rtl/ppra_div.sv
hw/rtl/paged_process_resize_allocator_top.sv
test/testbench.sv
